// ----- design/crsd_pkg.sv -----
// ----------------------------------------------------------------------------
// crsd_pkg
// Shared constants and types for the cable robot step delta unit.
// ----------------------------------------------------------------------------
package crsd_pkg;

  localparam int SPAN_W          = 23;
  localparam int SCALE_W         = 24;
  localparam int OUT_W           = 31;
  localparam int COORD_BITS_DEF  = 24;
  localparam int SCALE_FRAC_DEF  = 20;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [SPAN_W-1:0]  HALF_SPAN_Y_RST  = SPAN_W'(1000000);
  localparam logic [SPAN_W-1:0]  HALF_SPAN_X_RST  = SPAN_W'(1000000);
  localparam logic [SCALE_W-1:0] STEPS_PER_UM_RST = SCALE_W'(33554);

  typedef enum logic [1:0] {
    REG_HALF_SPAN_Y  = 2'd0,
    REG_HALF_SPAN_X  = 2'd1,
    REG_STEPS_PER_UM = 2'd2
  } reg_index_t;

endpackage

// ----- design/crsd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// crsd_sqrt_cell
// One restoring square root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module crsd_sqrt_cell #(
  parameter int ROOT_W = 25
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ROOT_W+1:0]     rem_in,
  input  logic [ROOT_W-1:0]     root_in,
  input  logic [2*ROOT_W-1:0]   rad_in,
  output logic [ROOT_W+1:0]     rem_out,
  output logic [ROOT_W-1:0]     root_out,
  output logic [2*ROOT_W-1:0]   rad_out
);

  logic [ROOT_W+1:0] cat;
  logic [ROOT_W+1:0] trial;
  logic              fits;

  assign cat   = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
  assign trial = {root_in, 2'b01};
  assign fits  = cat >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= fits ? cat - trial : cat;
      root_out <= {root_in[ROOT_W-2:0], fits};
      rad_out  <= {rad_in[2*ROOT_W-3:0], 2'b00};
    end
  end

endmodule

// ----- design/crsd_sqrt_chain.sv -----
// ----------------------------------------------------------------------------
// crsd_sqrt_chain
// Row of square root cells, one root bit per cell, one radicand per cycle while en is high.
// ----------------------------------------------------------------------------
module crsd_sqrt_chain #(
  parameter int ROOT_W = 25
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic [ROOT_W-1:0]   root
);

  logic [ROOT_W+1:0]   rem_c  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_c [ROOT_W+1];
  logic [2*ROOT_W-1:0] rad_c  [ROOT_W+1];

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = radicand;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    crsd_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem_c[i]),
      .root_in  (root_c[i]),
      .rad_in   (rad_c[i]),
      .rem_out  (rem_c[i+1]),
      .root_out (root_c[i+1]),
      .rad_out  (rad_c[i+1])
    );
  end

  assign root = root_c[ROOT_W];

endmodule

// ----- design/crsd_scale.sv -----
// ----------------------------------------------------------------------------
// crsd_scale
// Length delta times steps per micrometre, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module crsd_scale
  import crsd_pkg::*;
#(
  parameter int ROOT_W    = 25,
  parameter int FRAC_BITS = SCALE_FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ROOT_W-1:0]       len_start,
  input  logic [ROOT_W-1:0]       len_target,
  input  logic [SCALE_W-1:0]      steps_per_um,
  output logic signed [OUT_W-1:0] steps,
  output logic                    sat
);

  localparam int PROD_W = ROOT_W + SCALE_W;
  localparam int SHR_W  = PROD_W - FRAC_BITS;
  localparam logic [63:0] POS_MAX = 64'd1073741823;
  localparam logic [63:0] NEG_MAX = 64'd1073741824;

  logic [ROOT_W-1:0] mag;
  logic              neg1;
  logic [PROD_W-1:0] prod;
  logic              neg2;
  logic [SHR_W-1:0]  shr;
  logic [63:0]       shr_ext;
  logic [OUT_W-1:0]  low;
  logic              over;

  assign shr     = prod[PROD_W-1:FRAC_BITS];
  assign shr_ext = 64'(shr);
  assign over    = neg2 ? (shr_ext > NEG_MAX) : (shr_ext > POS_MAX);
  assign low     = over ? (neg2 ? NEG_MAX[OUT_W-1:0] : POS_MAX[OUT_W-1:0])
                        : shr_ext[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= len_start < len_target;
      mag   <= (len_start < len_target) ? len_target - len_start
                                        : len_start - len_target;
      neg2  <= neg1;
      prod  <= PROD_W'(mag) * PROD_W'(steps_per_um);
      steps <= neg2 ? $signed(-low) : $signed(low);
      sat   <= over;
    end
  end

endmodule

// ----- design/cable_robot_step_delta_unit.sv -----
// ----------------------------------------------------------------------------
// cable_robot_step_delta_unit
// Four-cable inverse kinematics: step changes between a start and a target.
// ----------------------------------------------------------------------------
// Takes one point pair per cycle, unless the pipeline holds, and returns one
// result per pair through eight rows of square root cells in parallel (four
// cables, start and target), one root bit per cell. The pipeline holds as a
// whole while a finished result is not taken. Registers: half_span_y at 0x0,
// half_span_x at 0x4, steps_per_um (Q4.20) at 0x8; write them only while idle.
module cable_robot_step_delta_unit
  import crsd_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  input  logic signed [COORD_BITS-1:0] target_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      steps_motor_one,
  output logic signed [OUT_W-1:0]      steps_motor_two,
  output logic signed [OUT_W-1:0]      steps_motor_three,
  output logic signed [OUT_W-1:0]      steps_motor_four,
  output logic                         saturated
);

  localparam int MAG_W  = ((COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W) + 1;
  localparam int DW     = MAG_W + 1;
  localparam int ROOT_W = MAG_W + 1;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int LAT    = ROOT_W + 6;

  logic [SPAN_W-1:0]  half_span_y;
  logic [SPAN_W-1:0]  half_span_x;
  logic [SCALE_W-1:0] steps_per_um;
  logic               wr;
  reg_index_t         widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_span_y  <= HALF_SPAN_Y_RST;
      half_span_x  <= HALF_SPAN_X_RST;
      steps_per_um <= STEPS_PER_UM_RST;
    end else if (wr) begin
      unique case (widx)
        REG_HALF_SPAN_Y:  half_span_y  <= pwdata[SPAN_W-1:0];
        REG_HALF_SPAN_X:  half_span_x  <= pwdata[SPAN_W-1:0];
        REG_STEPS_PER_UM: steps_per_um <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_HALF_SPAN_Y:  prdata = DATA_W'(half_span_y);
      REG_HALF_SPAN_X:  prdata = DATA_W'(half_span_x);
      REG_STEPS_PER_UM: prdata = DATA_W'(steps_per_um);
      default:          prdata = '0;
    endcase
  end

  logic           en;
  logic [LAT-1:0] vld;

  assign out_valid = vld[LAT-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  logic signed [DW-1:0] hx, hy;
  logic signed [DW-1:0] px [2];
  logic signed [DW-1:0] py [2];
  logic signed [DW-1:0] pz [2];

  assign hx    = $signed({{(DW-SPAN_W){1'b0}}, half_span_x});
  assign hy    = $signed({{(DW-SPAN_W){1'b0}}, half_span_y});
  assign px[0] = $signed({{(DW-COORD_BITS){start_x[COORD_BITS-1]}}, start_x});
  assign py[0] = $signed({{(DW-COORD_BITS){start_y[COORD_BITS-1]}}, start_y});
  assign pz[0] = $signed({{(DW-COORD_BITS){start_z[COORD_BITS-1]}}, start_z});
  assign px[1] = $signed({{(DW-COORD_BITS){target_x[COORD_BITS-1]}}, target_x});
  assign py[1] = $signed({{(DW-COORD_BITS){target_y[COORD_BITS-1]}}, target_y});
  assign pz[1] = $signed({{(DW-COORD_BITS){target_z[COORD_BITS-1]}}, target_z});

  logic [MAG_W-1:0]   ax   [8];
  logic [MAG_W-1:0]   ay   [8];
  logic [MAG_W-1:0]   az   [8];
  logic [2*MAG_W-1:0] sqx  [8];
  logic [2*MAG_W-1:0] sqy  [8];
  logic [2*MAG_W-1:0] sqz  [8];
  logic [SUM_W-1:0]   sum  [8];
  logic [ROOT_W-1:0]  len  [8];

  for (genvar l = 0; l < 8; l++) begin : g_lane
    localparam int P = l / 4;
    localparam int M = l % 4;

    always_ff @(posedge clk) begin
      if (en) begin
        ax[l]  <= (M == 0 || M == 2) ? mag_of(hx + px[P]) : mag_of(hx - px[P]);
        ay[l]  <= (M < 2) ? mag_of(hy - py[P]) : mag_of(hy + py[P]);
        az[l]  <= mag_of(pz[P]);
        sqx[l] <= ax[l] * ax[l];
        sqy[l] <= ay[l] * ay[l];
        sqz[l] <= az[l] * az[l];
        sum[l] <= SUM_W'(sqx[l]) + SUM_W'(sqy[l]) + SUM_W'(sqz[l]);
      end
    end

    crsd_sqrt_chain #(.ROOT_W(ROOT_W)) u_root (
      .clk      (clk),
      .en       (en),
      .radicand (sum[l]),
      .root     (len[l])
    );
  end

  logic signed [OUT_W-1:0] steps [4];
  logic [3:0]              sat;

  for (genvar m = 0; m < 4; m++) begin : g_motor
    crsd_scale #(.ROOT_W(ROOT_W), .FRAC_BITS(SCALE_FRAC_BITS)) u_scale (
      .clk          (clk),
      .en           (en),
      .len_start    (len[m]),
      .len_target   (len[m+4]),
      .steps_per_um (steps_per_um),
      .steps        (steps[m]),
      .sat          (sat[m])
    );
  end

  assign steps_motor_one   = steps[0];
  assign steps_motor_two   = steps[1];
  assign steps_motor_three = steps[2];
  assign steps_motor_four  = steps[3];
  assign saturated         = |sat;

endmodule
